### hw/rtl/ptf_pkg.sv
// ----------------------------------------------------------------------------
// ptf_pkg: shared types and constants of the palette tint/fade unit
// channel width of rgb555, register indexes and the per-channel tint function
// ----------------------------------------------------------------------------
`default_nettype none

package ptf_pkg;

	localparam int ChW       = 5;
	localparam int ColorW    = 16;
	localparam int TintW     = 15;
	localparam int DeltaW    = 8;
	localparam int LevelW    = 8;
	localparam int AccW      = 16;
	localparam int CfgIdxW   = 2;
	localparam int CfgDataW  = 16;

	localparam logic [ChW-1:0] ChMax = 5'd31;

	typedef logic [ChW-1:0]    chan_t;
	typedef logic [LevelW-1:0] level_t;
	typedef logic [AccW-1:0]   acc_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_RED_DELTA   = 2'd0,
		CFG_GREEN_DELTA = 2'd1,
		CFG_BLUE_DELTA  = 2'd2,
		CFG_FADE_RATE   = 2'd3
	} cfg_idx_t;

	// channel plus delta times level, clamped to 0..31
	// 17-bit signed holds -32640..32416 without wrap
	function automatic chan_t tint_ch(chan_t ch, logic signed [DeltaW-1:0] delta,
			level_t level);
		logic signed [16:0] prod;
		logic signed [16:0] sum;
		chan_t              res;
		prod = 17'(delta * $signed({1'b0, level}));
		sum  = prod + $signed({12'd0, ch});
		if (sum < 0) begin
			res = '0;
		end else if (sum > $signed({12'd0, ChMax})) begin
			res = ChMax;
		end else begin
			res = sum[ChW-1:0];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/ptf_if.sv
// ----------------------------------------------------------------------------
// ptf_if: stream interfaces of the palette tint/fade unit
// base colour words in, tinted colour words out, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface ptf_base_if;
	logic                       valid;
	logic                       ready;
	logic [ptf_pkg::ColorW-1:0] base_color;
	logic                       pass_end;

	modport source (output valid, output base_color, output pass_end, input ready);
	modport sink   (input valid, input base_color, input pass_end, output ready);
endinterface

interface ptf_tint_if;
	logic                      valid;
	logic                      ready;
	logic [ptf_pkg::TintW-1:0] tinted_color;
	logic                      result_last;

	modport source (output valid, output tinted_color, output result_last, input ready);
	modport sink   (input valid, input tinted_color, input result_last, output ready);
endinterface

`default_nettype wire

### hw/rtl/palette_tint_fade_rgb555_top.sv
// ----------------------------------------------------------------------------
// palette_tint_fade_rgb555_top: rgb555 palette tint with per-pass fade level
// base word goes through input reg, then result reg, before its tint word is valid
// one word per cycle unless tint stalls; that back-pressures base via the result reg
// arst_n clears valids, fade accumulator, fade level and the delta/rate registers
// ----------------------------------------------------------------------------
`default_nettype none

module palette_tint_fade_rgb555_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [ptf_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [ptf_pkg::CfgDataW-1:0] cfg_data,
	ptf_base_if.sink                          base,
	ptf_tint_if.source                        tint
);

	// configuration registers
	logic [ptf_pkg::DeltaW-1:0] red_delta_q;
	logic [ptf_pkg::DeltaW-1:0] green_delta_q;
	logic [ptf_pkg::DeltaW-1:0] blue_delta_q;
	ptf_pkg::acc_t              fade_rate_q;

	// fade state, advanced when a pass-end word is taken
	ptf_pkg::acc_t   fade_acc_q;
	ptf_pkg::level_t fade_level_q;

	// stage 1: captured word with the level that applied when it arrived
	logic                      valid_s1;
	logic [ptf_pkg::TintW-1:0] color_s1;
	logic                      last_s1;
	ptf_pkg::level_t           level_s1;

	// stage 2: result register, drives the tint channel
	logic                      valid_s2;
	logic [ptf_pkg::TintW-1:0] tint_s2;
	logic                      last_s2;

	logic          take_base;
	logic          move_s2;
	logic          move_s1;
	ptf_pkg::acc_t fade_acc_next;
	ptf_pkg::chan_t r_ch, g_ch, b_ch;

	// result register frees when empty or being taken; stage 1 frees likewise
	assign move_s2   = !valid_s2 || tint.ready;
	assign move_s1   = !valid_s1 || move_s2;
	assign base.ready = move_s1;
	assign take_base = base.valid && base.ready;

	assign fade_acc_next = fade_acc_q + fade_rate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_delta_q   <= '0;
			green_delta_q <= '0;
			blue_delta_q  <= '0;
			fade_rate_q   <= '0;
		end else if (cfg_we) begin
			case (ptf_pkg::cfg_idx_t'(cfg_index))
				ptf_pkg::CFG_RED_DELTA:   red_delta_q   <= cfg_data[ptf_pkg::DeltaW-1:0];
				ptf_pkg::CFG_GREEN_DELTA: green_delta_q <= cfg_data[ptf_pkg::DeltaW-1:0];
				ptf_pkg::CFG_BLUE_DELTA:  blue_delta_q  <= cfg_data[ptf_pkg::DeltaW-1:0];
				ptf_pkg::CFG_FADE_RATE:   fade_rate_q   <= cfg_data[ptf_pkg::AccW-1:0];
				default: ;
			endcase
		end
	end

	// level update lands after the pass-end word has latched the old level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_acc_q   <= '0;
			fade_level_q <= '0;
		end else if (take_base && base.pass_end) begin
			fade_acc_q   <= fade_acc_next;
			fade_level_q <= fade_acc_next[ptf_pkg::AccW-1 -: ptf_pkg::LevelW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (move_s1) begin
			valid_s1 <= base.valid;
		end
	end

	// bit 15 of the base word is not kept
	always_ff @(posedge clk) begin
		if (take_base) begin
			color_s1 <= base.base_color[ptf_pkg::TintW-1:0];
			last_s1  <= base.pass_end;
			level_s1 <= fade_level_q;
		end
	end

	// three independent multiply-and-clamp paths
	assign r_ch = ptf_pkg::tint_ch(color_s1[4:0],   $signed(red_delta_q),   level_s1);
	assign g_ch = ptf_pkg::tint_ch(color_s1[9:5],   $signed(green_delta_q), level_s1);
	assign b_ch = ptf_pkg::tint_ch(color_s1[14:10], $signed(blue_delta_q),  level_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (move_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s2 && valid_s1) begin
			tint_s2 <= {b_ch, g_ch, r_ch};
			last_s2 <= last_s1;
		end
	end

	assign tint.valid        = valid_s2;
	assign tint.tinted_color = tint_s2;
	assign tint.result_last  = last_s2;

endmodule

`default_nettype wire

### hw/rtl/ptf_checker.sv
// ----------------------------------------------------------------------------
// ptf_checker: port-level checks of the palette tint/fade unit
// stall hold, back-pressure cause and no-phantom result checks, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module ptf_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      base_valid,
	input wire logic                      base_ready,
	input wire logic                      tint_valid,
	input wire logic                      tint_ready,
	input wire logic [ptf_pkg::TintW-1:0] tinted_color,
	input wire logic                      result_last
);

	logic base_take;
	assign base_take = base_valid && base_ready;

	// a stalled result word holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tint_valid && !tint_ready |=> tint_valid && $stable(tinted_color)
			&& $stable(result_last))
		else $error("tint word changed while stalled");

	// base only back-pressured by a full, stalled result register
	a_bp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!base_ready |-> tint_valid && !tint_ready)
		else $error("base stalled without a tint stall");

	// no result appears without a base word taken that can reach the result register through stage 1
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!tint_valid && !base_take && !$past(base_take) |=> !tint_valid)
		else $error("tint word with no base word behind it");

endmodule

bind palette_tint_fade_rgb555_top ptf_checker u_ptf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.base_valid   (base.valid),
	.base_ready   (base.ready),
	.tint_valid   (tint.valid),
	.tint_ready   (tint.ready),
	.tinted_color (tint.tinted_color),
	.result_last  (tint.result_last)
);

`default_nettype wire
